@@ rtl/ffd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field extract and decode: shared package
// Types, codes and character helpers used by the form field decoder.
// ----------------------------------------------------------------------------
package ffd_pkg;

  localparam int MAX_KEY_LENGTH_DEFAULT = 15;
  localparam int KEY_REG_CHARS = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_HIGH_W = 56;
  localparam int KEY_LEN_W = 4;
  localparam int GROUP_SIZE = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN = 2'd2;

  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_PCT = 8'h25;
  localparam logic [7:0] CHAR_AMP = 8'h26;
  localparam logic [7:0] CHAR_EQ = 8'h3D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_VALUE  = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE = 2'd0,
    DS_PCT  = 2'd1,
    DS_HEX1 = 2'd2
  } dstate_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       key_found;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [2:0]            count;
    res_t [GROUP_SIZE-1:0] item;
  } grp_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end
    hex_val = d[3:0];
  endfunction

endpackage

@@ rtl/ffd_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field extract and decode: key match
// Holds the window of recent body bytes and flags a key followed by '='.
// ----------------------------------------------------------------------------
module ffd_match #(
  parameter int MAX_KEY_LENGTH = ffd_pkg::MAX_KEY_LENGTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         searching,
  input  logic [7:0]                   body_byte,
  input  logic                         body_end,
  input  logic [63:0]                  key_chars_low,
  input  logic [ffd_pkg::KEY_HIGH_W-1:0] key_chars_high,
  input  logic [ffd_pkg::KEY_LEN_W-1:0]  key_length,
  output logic                         match
);

  localparam int WinDepth = (MAX_KEY_LENGTH < ffd_pkg::KEY_REG_CHARS) ?
                            MAX_KEY_LENGTH : ffd_pkg::KEY_REG_CHARS;
  localparam logic [3:0] LenCap = 4'(WinDepth);

  logic [7:0] win [WinDepth];
  logic [7:0] key_arr [16];
  logic [3:0] lim;
  logic [3:0] eff_len;
  logic [3:0] kidx [WinDepth];
  logic       ok;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_arr[i] = key_chars_low[8*i +: 8];
    end
    for (int i = 0; i < 7; i++) begin
      key_arr[8+i] = key_chars_high[8*i +: 8];
    end
    key_arr[15] = ffd_pkg::CHAR_NUL;
  end

  always_comb begin
    lim = (key_length > LenCap) ? LenCap : key_length;
    eff_len = lim;
    for (int i = ffd_pkg::KEY_REG_CHARS - 1; i >= 0; i--) begin
      if (4'(i) < lim && key_arr[i] == ffd_pkg::CHAR_NUL) begin
        eff_len = 4'(i);
      end
    end
  end

  // Window entry j holds the byte j+1 places before the current one, so it
  // must equal key character eff_len-1-j.
  always_comb begin
    ok = 1'b1;
    for (int j = 0; j < WinDepth; j++) begin
      kidx[j] = eff_len - 4'(j) - 4'd1;
      if (4'(j) < eff_len && win[j] != key_arr[kidx[j]]) begin
        ok = 1'b0;
      end
    end
    match = ok && (body_byte == ffd_pkg::CHAR_EQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WinDepth; j++) begin
        win[j] <= 8'h00;
      end
    end else if (step) begin
      if (body_end) begin
        for (int j = 0; j < WinDepth; j++) begin
          win[j] <= 8'h00;
        end
      end else if (searching) begin
        win[0] <= body_byte;
        for (int j = 1; j < WinDepth; j++) begin
          win[j] <= win[j-1];
        end
      end
    end
  end

endmodule

@@ rtl/ffd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field extract and decode: value decoder
// Tracks the search phase and percent escapes and builds the result group
// that one body byte produces.
// ----------------------------------------------------------------------------
module ffd_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    body_byte,
  input  logic          body_end,
  input  logic          match,
  output logic          searching,
  output ffd_pkg::grp_t grp
);

  ffd_pkg::phase_t  phase, phase_next;
  ffd_pkg::dstate_t dstate, dstate_next;
  logic [7:0]       held, held_next;
  logic [2:0]       n;
  logic             found;

  assign searching = (phase == ffd_pkg::PH_SEARCH);

  always_comb begin
    phase_next = phase;
    dstate_next = dstate;
    held_next = held;
    n = 3'd0;
    found = 1'b0;
    grp = '0;
    case (phase)
      ffd_pkg::PH_SEARCH: begin
        if (match) begin
          phase_next = ffd_pkg::PH_VALUE;
          dstate_next = ffd_pkg::DS_NONE;
          held_next = 8'h00;
        end
      end
      ffd_pkg::PH_VALUE: begin
        if (dstate == ffd_pkg::DS_PCT && ffd_pkg::is_hex(body_byte)) begin
          held_next = body_byte;
          dstate_next = ffd_pkg::DS_HEX1;
        end else if (dstate == ffd_pkg::DS_HEX1 && ffd_pkg::is_hex(body_byte)) begin
          grp.item[n[1:0]] = '{{ffd_pkg::hex_val(held), ffd_pkg::hex_val(body_byte)},
                               1'b1, 1'b0, 1'b0};
          n = n + 3'd1;
          dstate_next = ffd_pkg::DS_NONE;
          held_next = 8'h00;
        end else begin
          if (dstate == ffd_pkg::DS_PCT || dstate == ffd_pkg::DS_HEX1) begin
            grp.item[n[1:0]] = '{ffd_pkg::CHAR_PCT, 1'b1, 1'b0, 1'b0};
            n = n + 3'd1;
          end
          if (dstate == ffd_pkg::DS_HEX1) begin
            grp.item[n[1:0]] = '{held, 1'b1, 1'b0, 1'b0};
            n = n + 3'd1;
          end
          dstate_next = ffd_pkg::DS_NONE;
          held_next = 8'h00;
          if (body_byte == ffd_pkg::CHAR_AMP || body_byte == ffd_pkg::CHAR_NUL) begin
            phase_next = ffd_pkg::PH_DONE;
          end else if (body_byte == ffd_pkg::CHAR_PLUS) begin
            grp.item[n[1:0]] = '{ffd_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0};
            n = n + 3'd1;
          end else if (body_byte == ffd_pkg::CHAR_PCT) begin
            dstate_next = ffd_pkg::DS_PCT;
          end else begin
            grp.item[n[1:0]] = '{body_byte, 1'b1, 1'b0, 1'b0};
            n = n + 3'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (body_end) begin
      found = (phase_next != ffd_pkg::PH_SEARCH);
      if (phase_next == ffd_pkg::PH_VALUE) begin
        if (dstate_next == ffd_pkg::DS_PCT || dstate_next == ffd_pkg::DS_HEX1) begin
          grp.item[n[1:0]] = '{ffd_pkg::CHAR_PCT, 1'b1, 1'b0, 1'b0};
          n = n + 3'd1;
        end
        if (dstate_next == ffd_pkg::DS_HEX1) begin
          grp.item[n[1:0]] = '{held_next, 1'b1, 1'b0, 1'b0};
          n = n + 3'd1;
        end
      end
      grp.item[n[1:0]] = '{8'h00, 1'b0, found, 1'b1};
      n = n + 3'd1;
      phase_next = ffd_pkg::PH_SEARCH;
      dstate_next = ffd_pkg::DS_NONE;
      held_next = 8'h00;
    end
    grp.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ffd_pkg::PH_SEARCH;
      dstate <= ffd_pkg::DS_NONE;
      held <= 8'h00;
    end else if (step) begin
      phase <= phase_next;
      dstate <= dstate_next;
      held <= held_next;
    end
  end

endmodule

@@ rtl/ffd_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field extract and decode: result serializer
// Holds one result group and hands its words out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ffd_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ffd_pkg::grp_t grp_in,
  output logic          room,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [7:0]    value_byte,
  output logic          byte_valid,
  output logic          key_found,
  output logic          last
);

  ffd_pkg::grp_t grp;
  logic          grp_v;
  logic [1:0]    idx;
  logic          pop;
  logic          pop_last;
  ffd_pkg::res_t cur;

  assign cur = grp.item[idx];
  assign result_valid = grp_v;
  assign value_byte = cur.value_byte;
  assign byte_valid = cur.byte_valid;
  assign key_found = cur.key_found;
  assign last = cur.last;

  assign pop = grp_v && !result_stall;
  assign pop_last = pop && ({1'b0, idx} == grp.count - 3'd1);
  assign room = !grp_v || pop_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_v <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      grp_v <= 1'b1;
      idx <= 2'd0;
    end else if (pop_last) begin
      grp_v <= 1'b0;
      idx <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

@@ rtl/form_field_extract_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form field extract and decode
// Extracts and percent-decodes the value of one key from a URL-encoded body.
// ----------------------------------------------------------------------------
// Body bytes enter one per cycle, unless stalled, into an input register.
// The next cycle the key window compare and the decode step turn the byte
// into a group of zero to four result words, which a group register hands
// out one word per cycle unless result_stall is high. A byte that makes at
// most one word keeps one byte per cycle unless results stall; one making
// more holds the input until the single result port drains the group. The
// user must write the key registers through the cfg port while no body is in
// flight, unchecked by the block; key_length resets to one.
module form_field_extract_decode #(
  parameter int MAX_KEY_LENGTH = ffd_pkg::MAX_KEY_LENGTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              body_valid,
  output logic                              body_stall,
  input  logic [7:0]                        body_byte,
  input  logic                              body_end,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [7:0]                        value_byte,
  output logic                              byte_valid,
  output logic                              key_found,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic [ffd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ffd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [63:0]                    key_chars_low;
  logic [ffd_pkg::KEY_HIGH_W-1:0] key_chars_high;
  logic [ffd_pkg::KEY_LEN_W-1:0]  key_length;

  logic          in_v;
  logic [7:0]    in_byte;
  logic          in_end;
  logic          adv;
  logic          room;
  logic          match;
  logic          searching;
  ffd_pkg::grp_t grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars_low <= '0;
      key_chars_high <= '0;
      key_length <= 4'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        ffd_pkg::REG_KEY_LOW:  key_chars_low <= cfg_data;
        ffd_pkg::REG_KEY_HIGH: key_chars_high <= cfg_data[ffd_pkg::KEY_HIGH_W-1:0];
        ffd_pkg::REG_KEY_LEN:  key_length <= cfg_data[ffd_pkg::KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv = in_v && (grp.count == 3'd0 || room);
  assign body_stall = in_v && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (body_valid && !body_stall) begin
      in_v <= 1'b1;
    end else if (adv) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (body_valid && !body_stall) begin
      in_byte <= body_byte;
      in_end <= body_end;
    end
  end

  ffd_match #(
    .MAX_KEY_LENGTH(MAX_KEY_LENGTH)
  ) u_match (
    .clk           (clk),
    .rst           (rst),
    .step          (adv),
    .searching     (searching),
    .body_byte     (in_byte),
    .body_end      (in_end),
    .key_chars_low (key_chars_low),
    .key_chars_high(key_chars_high),
    .key_length    (key_length),
    .match         (match)
  );

  ffd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (adv),
    .body_byte(in_byte),
    .body_end (in_end),
    .match    (match),
    .searching(searching),
    .grp      (grp)
  );

  ffd_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (adv && grp.count != 3'd0),
    .grp_in      (grp),
    .room        (room),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .value_byte  (value_byte),
    .byte_valid  (byte_valid),
    .key_found   (key_found),
    .last        (last)
  );

endmodule
